// ===== hw/rtl/mee_pkg.sv =====
// Shared types, constants and the letter shape table of the Morse element encoder.
package mee_pkg;

  // Character codes and table bounds.
  localparam logic [7:0] FIRST_LETTER = 8'd65;
  localparam logic [7:0] LAST_LETTER  = 8'd90;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam int         NUM_LETTERS  = 26;

  // Element lengths in Morse units.
  localparam logic [2:0] DOT_UNITS        = 3'd1;
  localparam logic [2:0] DASH_UNITS       = 3'd3;
  localparam logic [2:0] INNER_GAP_UNITS  = 3'd1;
  localparam logic [2:0] LETTER_GAP_UNITS = 3'd3;
  localparam logic [2:0] WORD_GAP_UNITS   = 3'd7;
  localparam logic [2:0] ERROR_UNITS      = 3'd0;

  localparam logic [15:0] UNIT_TICKS_RESET = 16'd25000;

  // Input command codes.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // What the back end has to play for one request.
  typedef enum logic [1:0] {
    KIND_WORD,
    KIND_LETTER,
    KIND_BAD
  } kind_t;

  // Shape of one letter: element count and dash flags, bit 0 is the first element.
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] dashes;
  } shape_t;

  // Descriptor handed from the front end to the back end through the queue.
  typedef struct packed {
    kind_t      kind;
    logic       lead_gap;
    shape_t     shape;
  } desc_t;

  localparam shape_t LETTER_SHAPES [NUM_LETTERS] = '{
    '{3'd2, 4'b0010},  // A .-
    '{3'd4, 4'b0001},  // B -...
    '{3'd4, 4'b0101},  // C -.-.
    '{3'd3, 4'b0001},  // D -..
    '{3'd1, 4'b0000},  // E .
    '{3'd4, 4'b0100},  // F ..-.
    '{3'd3, 4'b0011},  // G --.
    '{3'd4, 4'b0000},  // H ....
    '{3'd2, 4'b0000},  // I ..
    '{3'd4, 4'b1110},  // J .---
    '{3'd3, 4'b0101},  // K -.-
    '{3'd4, 4'b0010},  // L .-..
    '{3'd2, 4'b0011},  // M --
    '{3'd2, 4'b0001},  // N -.
    '{3'd3, 4'b0111},  // O ---
    '{3'd4, 4'b0110},  // P .--.
    '{3'd4, 4'b1011},  // Q --.-
    '{3'd3, 4'b0010},  // R .-.
    '{3'd3, 4'b0000},  // S ...
    '{3'd1, 4'b0001},  // T -
    '{3'd3, 4'b0100},  // U ..-
    '{3'd4, 4'b1000},  // V ...-
    '{3'd3, 4'b0110},  // W .--
    '{3'd4, 4'b1001},  // X -..-
    '{3'd4, 4'b1101},  // Y -.--
    '{3'd4, 4'b0011}   // Z --..
  };

endpackage

// ===== hw/rtl/mee_front.sv =====
// Front end: accepts characters, classifies them and tracks the letter-gap state.
module mee_front import mee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  output logic        push,
  output desc_t       push_data,
  input  logic        push_ready
);

  logic       prev_letter_r;
  logic       prev_letter_nxt;
  logic       is_word;
  logic       is_letter;
  logic [4:0] letter_idx;

  assign in_tready = push_ready;
  assign push      = in_tvalid && push_ready;

  // Classify the character.
  assign is_word    = (in_tuser == CMD_END) || (in_tdata == SPACE_CODE);
  assign is_letter  = (in_tdata >= FIRST_LETTER) && (in_tdata <= LAST_LETTER);
  assign letter_idx = 5'(in_tdata - FIRST_LETTER);

  always_comb begin
    push_data.lead_gap = 1'b0;
    push_data.shape    = '{3'd1, 4'b0000};
    prev_letter_nxt    = prev_letter_r;
    if (is_word) begin
      push_data.kind  = KIND_WORD;
      prev_letter_nxt = 1'b0;
    end else if (is_letter) begin
      push_data.kind     = KIND_LETTER;
      push_data.lead_gap = prev_letter_r;
      push_data.shape    = LETTER_SHAPES[letter_idx];
      prev_letter_nxt    = 1'b1;
    end else begin
      // Invalid characters leave the letter-gap state alone.
      push_data.kind = KIND_BAD;
    end
  end

  // The state moves only when a request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_letter_r <= 1'b0;
    end else if (push) begin
      prev_letter_r <= prev_letter_nxt;
    end
  end

endmodule

// ===== hw/rtl/mee_fifo.sv =====
// Short descriptor queue between the front end and the back end.
module mee_fifo import mee_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  push_ready,
  input  logic  pop,
  output desc_t pop_data,
  output logic  pop_valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != FULL_CNT) || pop) else $error("push into full queue");
`endif

endmodule

// ===== hw/rtl/mee_back.sv =====
// Back end: plays each descriptor out as keying elements into the output register.
module mee_back import mee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        q_valid,
  input  desc_t       q_data,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic [15:0] unit_ticks_r;
  logic        busy_r;
  desc_t       desc_r;
  logic [2:0]  slot_r;
  logic        out_valid_r;
  logic        key_r;
  logic [2:0]  units_r;
  logic [18:0] ticks_r;
  logic        bad_r;
  logic        last_r;

  logic        adv;
  logic        emit;
  logic [2:0]  last_slot;
  logic        key_c;
  logic [2:0]  units_c;
  logic        bad_c;
  logic        last_c;
  logic [18:0] ticks_c;

  assign adv       = !out_valid_r || out_tready;
  assign emit      = busy_r && adv;
  assign q_pop     = !busy_r && q_valid;
  // A letter of n elements ends at slot 2n-1; slot 0 is the letter gap.
  assign last_slot = 3'({1'b0, desc_r.shape.len, 1'b0} - 4'd1);

  // Element at the current slot.
  always_comb begin
    key_c   = 1'b0;
    units_c = ERROR_UNITS;
    bad_c   = 1'b0;
    last_c  = 1'b1;
    unique case (desc_r.kind)
      KIND_WORD: begin
        units_c = WORD_GAP_UNITS;
      end
      KIND_LETTER: begin
        last_c = (slot_r == last_slot);
        if (slot_r == 3'd0) begin
          units_c = LETTER_GAP_UNITS;
        end else if (slot_r[0]) begin
          key_c   = 1'b1;
          units_c = desc_r.shape.dashes[slot_r[2:1]] ? DASH_UNITS : DOT_UNITS;
        end else begin
          units_c = INNER_GAP_UNITS;
        end
      end
      default: begin
        bad_c = 1'b1;
      end
    endcase
  end

  assign ticks_c = 19'(units_c) * 19'(unit_ticks_r);

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RESET;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unit_ticks_r <= cfg_wdata;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && last_c) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Descriptor, slot and result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_data;
      slot_r <= q_data.lead_gap ? 3'd0 : 3'd1;
    end else if (emit) begin
      slot_r <= slot_r + 3'd1;
    end
    if (emit) begin
      key_r   <= key_c;
      units_r <= units_c;
      ticks_r <= ticks_c;
      bad_r   <= bad_c;
      last_r  <= last_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, ticks_r, units_r, key_r};
  assign out_tuser  = bad_r;
  assign out_tlast  = last_r;

`ifndef NO_ASSERTIONS
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bad_r |-> last_r && (units_r == ERROR_UNITS) && !key_r)
    else $error("error result is not a lone final element");
  a_mark_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && key_r |-> (units_r == DOT_UNITS) || (units_r == DASH_UNITS))
    else $error("mark with bad length");
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (desc_r.kind == KIND_LETTER) |-> slot_r <= last_slot)
    else $error("slot ran past the letter");
  a_mark_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit && last_c && (desc_r.kind == KIND_LETTER) |=> key_r)
    else $error("letter did not end on a mark");
`endif

endmodule

// ===== hw/rtl/morse_element_encoder_core.sv =====
// Top level of the Morse element encoder: front end, descriptor queue and back end.
//
//  channel  | direction | tdata                            | tuser    | tlast
//  in_      | slave     | [7:0] char_code                  | cmd      | -
//  out_     | master    | [0] key_on [3:1] units           | bad_char | last
//           |           | [22:4] duration_ticks [23] zero  |          |
//  cfg_     | write     | cfg_wdata = unit_ticks           | -        | -
//
// The back end gives one element per cycle while the output is not stalled; it takes the
// next descriptor from the queue only after the last element of the current one is given.
// The queue of QUEUE_DEPTH descriptors lets the input side take requests while the
// back end or the output stalls. Reset is synchronous, active low, and sets
// unit_ticks to 25000 and clears the letter-gap state.
module morse_element_encoder_core import mee_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // unit_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  input  logic        in_tuser,    // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [0] key_on, [3:1] units, [22:4] duration_ticks
  output logic        out_tuser,   // [0] bad_char
  output logic        out_tlast
);

  logic  push;
  logic  push_ready;
  desc_t push_data;
  logic  q_pop;
  logic  q_valid;
  desc_t q_data;

  mee_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  mee_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  mee_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
